// File: hw/rtl/cpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous page allocator package
// Sizes, placement rule codes, stream widths and sequencer states.
// ----------------------------------------------------------------------------
package cpa_pkg;

	// Page map and expiry table depth, with the index and count widths
	// that follow from it.
	localparam int PAGES   = 32;
	localparam int PAGE_W  = $clog2(PAGES);
	localparam int CNT_W   = $clog2(PAGES + 1);

	// Stream widths: fields packed from bit 0 up, padded to whole bytes.
	localparam int IN_W    = 80;
	localparam int OUT_W   = 16;

	// Placement rule codes of the fit_strategy register.
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	typedef logic [7:0]  job_id_t;
	typedef logic [31:0] time_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPIRE,
		ST_SEARCH,
		ST_ALLOC,
		ST_FINISH
	} state_t;

endpackage

// File: hw/rtl/contiguous_page_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous page allocator unit
// Places job arrivals into a page map by first, best or worst fit after
// releasing every job that has expired by the arrival time.
// ----------------------------------------------------------------------------
// Each job arrival passes from its transfer to its result through these
// steps: capture, the expiry scan, which checks one expiry table entry per
// cycle and releases the pages of an expired job in that same cycle, the
// hole scan, which walks the page map one page per cycle, tagging of the
// chosen run, and the load of the result register, which waits while an
// earlier result is still not taken. A new arrival is taken only when the
// sequencer is idle; it may arrive while the previous result still waits to
// be taken. The placement rule is written through cfg_wr_en/cfg_wr_data and
// should only change while no arrival is in progress.

module contiguous_page_allocator_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	// Configuration: fit_strategy
	input  logic                    cfg_wr_en,
	input  logic [1:0]              cfg_wr_data,
	// Arrivals
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// s_tdata from bit 0: job_id[7:0], arrival_time[39:8], page_count[45:40],
	// duration[77:46], zero pad[79:78]
	input  logic [cpa_pkg::IN_W-1:0]  s_tdata,
	// Results
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// m_tdata from bit 0: placed[0], start_page[5:1], freed_jobs[11:6],
	// zero pad[15:12]
	output logic [cpa_pkg::OUT_W-1:0] m_tdata
);

	// State and storage
	cpa_pkg::state_t                state_q, state_d;
	logic [1:0]                     fit_q;

	cpa_pkg::job_id_t               page_owner_q [cpa_pkg::PAGES];
	logic [cpa_pkg::PAGES-1:0]      exp_valid_q;
	cpa_pkg::job_id_t               exp_owner_q  [cpa_pkg::PAGES];
	cpa_pkg::time_t                 exp_time_q   [cpa_pkg::PAGES];

	cpa_pkg::job_id_t               job_id_q;
	cpa_pkg::time_t                 arrival_q;
	logic [5:0]                     size_q;
	cpa_pkg::time_t                 duration_q;

	logic [cpa_pkg::PAGE_W-1:0]     idx_q;
	logic [cpa_pkg::CNT_W-1:0]      pos_q;
	logic [cpa_pkg::CNT_W-1:0]      freed_q;
	logic [cpa_pkg::PAGE_W-1:0]     slot_q;
	logic                           have_slot_q;
	logic [cpa_pkg::PAGE_W-1:0]     run_start_q;
	logic [cpa_pkg::CNT_W-1:0]      run_len_q;
	logic                           found_q;
	logic [cpa_pkg::PAGE_W-1:0]     best_start_q;
	logic [cpa_pkg::CNT_W-1:0]      best_len_q;

	logic                           m_tvalid_q;
	logic                           out_placed_q;
	logic [4:0]                     out_start_q;
	logic [5:0]                     out_freed_q;

	// Combinational helpers
	logic                           accept;
	logic                           finish_load;
	cpa_pkg::job_id_t               cur_owner;
	logic                           expire_hit;
	logic [cpa_pkg::PAGES-1:0]      page_free;
	logic [cpa_pkg::PAGE_W-1:0]     pos_idx;
	logic                           cur_free;
	logic                           adequate;
	logic                           take_run;
	logic                           request_ok;
	logic                           place_ok;
	logic [32:0]                    end_sum;
	cpa_pkg::time_t                 end_time;
	logic [cpa_pkg::PAGES-1:0]      alloc_mask;

	assign accept      = s_tvalid && s_tready;
	assign s_tready    = (state_q == cpa_pkg::ST_IDLE);
	assign finish_load = (state_q == cpa_pkg::ST_FINISH) && (!m_tvalid_q || m_tready);

	// Expiry compare on the entry under the scan counter.
	assign cur_owner  = exp_owner_q[idx_q];
	assign expire_hit = exp_valid_q[idx_q] && (exp_time_q[idx_q] <= arrival_q);

	// Free map and the page under the hole scan counter.
	always_comb begin
		for (int p = 0; p < cpa_pkg::PAGES; p++) begin
			page_free[p] = (page_owner_q[p] == '0);
		end
	end

	assign pos_idx  = pos_q[cpa_pkg::PAGE_W-1:0];
	assign cur_free = (int'(pos_q) < cpa_pkg::PAGES) && page_free[pos_idx];

	// A run closes on a busy page or past the end; judge it against the best.
	assign adequate = !cur_free && (32'(run_len_q) >= 32'(size_q)) && (run_len_q != '0);
	assign take_run = adequate && (!found_q ||
		((fit_q == cpa_pkg::FIT_BEST)  && (run_len_q < best_len_q)) ||
		((fit_q == cpa_pkg::FIT_WORST) && (run_len_q > best_len_q)));

	assign request_ok = (job_id_q != '0) && (size_q != '0) &&
		(int'(size_q) <= cpa_pkg::PAGES) && (fit_q <= cpa_pkg::FIT_WORST) && have_slot_q;
	assign place_ok   = request_ok && found_q;

	// End time saturates at the largest time value.
	assign end_sum  = {1'b0, arrival_q} + {1'b0, duration_q};
	assign end_time = end_sum[32] ? '1 : end_sum[31:0];

	// Pages covered by the chosen run.
	always_comb begin
		for (int p = 0; p < cpa_pkg::PAGES; p++) begin
			alloc_mask[p] = (int'(best_start_q) <= p) &&
				(p < int'(best_start_q) + int'(size_q));
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpa_pkg::ST_IDLE: begin
				if (accept) state_d = cpa_pkg::ST_EXPIRE;
			end
			cpa_pkg::ST_EXPIRE: begin
				if (idx_q == cpa_pkg::PAGE_W'(cpa_pkg::PAGES - 1)) state_d = cpa_pkg::ST_SEARCH;
			end
			cpa_pkg::ST_SEARCH: begin
				if (pos_q == cpa_pkg::CNT_W'(cpa_pkg::PAGES)) state_d = cpa_pkg::ST_ALLOC;
			end
			cpa_pkg::ST_ALLOC: begin
				state_d = cpa_pkg::ST_FINISH;
			end
			cpa_pkg::ST_FINISH: begin
				if (finish_load) state_d = cpa_pkg::ST_IDLE;
			end
			default: begin
				state_d = cpa_pkg::ST_IDLE;
			end
		endcase
	end

	// Placement rule register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q <= cpa_pkg::FIT_FIRST;
		end else if (cfg_wr_en) begin
			fit_q <= cfg_wr_data;
		end
	end

	// Page map and expiry valid bits: releases during the expiry scan,
	// tagging in the allocation cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < cpa_pkg::PAGES; p++) begin
				page_owner_q[p] <= '0;
			end
			exp_valid_q <= '0;
		end else if ((state_q == cpa_pkg::ST_EXPIRE) && expire_hit) begin
			for (int p = 0; p < cpa_pkg::PAGES; p++) begin
				if (page_owner_q[p] == cur_owner) page_owner_q[p] <= '0;
			end
			exp_valid_q[idx_q] <= 1'b0;
		end else if ((state_q == cpa_pkg::ST_ALLOC) && place_ok) begin
			for (int p = 0; p < cpa_pkg::PAGES; p++) begin
				if (alloc_mask[p]) page_owner_q[p] <= job_id_q;
			end
			exp_valid_q[slot_q] <= 1'b1;
		end
	end

	// Expiry entry contents, written only when an entry is taken.
	always_ff @(posedge clk) begin
		if ((state_q == cpa_pkg::ST_ALLOC) && place_ok) begin
			exp_owner_q[slot_q] <= job_id_q;
			exp_time_q[slot_q]  <= end_time;
		end
	end

	// Arrival capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			job_id_q   <= s_tdata[7:0];
			arrival_q  <= s_tdata[39:8];
			size_q     <= s_tdata[45:40];
			duration_q <= s_tdata[77:46];
		end
	end

	// Scan counters, release count, free slot and best run bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			pos_q        <= '0;
			freed_q      <= '0;
			slot_q       <= '0;
			have_slot_q  <= 1'b0;
			run_start_q  <= '0;
			run_len_q    <= '0;
			found_q      <= 1'b0;
			best_start_q <= '0;
			best_len_q   <= '0;
		end else begin
			unique case (state_q)
				cpa_pkg::ST_IDLE: begin
					if (accept) begin
						idx_q        <= '0;
						pos_q        <= '0;
						freed_q      <= '0;
						slot_q       <= '0;
						have_slot_q  <= 1'b0;
						run_start_q  <= '0;
						run_len_q    <= '0;
						found_q      <= 1'b0;
						best_start_q <= '0;
						best_len_q   <= '0;
					end
				end
				cpa_pkg::ST_EXPIRE: begin
					if (expire_hit) freed_q <= freed_q + 1'b1;
					// The lowest entry that is free once this scan has passed it.
					if (!have_slot_q && (!exp_valid_q[idx_q] || expire_hit)) begin
						slot_q      <= idx_q;
						have_slot_q <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
				end
				cpa_pkg::ST_SEARCH: begin
					if (cur_free) begin
						if (run_len_q == '0) run_start_q <= pos_idx;
						run_len_q <= run_len_q + 1'b1;
					end else begin
						run_len_q <= '0;
					end
					if (take_run) begin
						found_q      <= 1'b1;
						best_start_q <= run_start_q;
						best_len_q   <= run_len_q;
					end
					pos_q <= pos_q + 1'b1;
				end
				cpa_pkg::ST_ALLOC, cpa_pkg::ST_FINISH: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Result register; an arrival may be taken while it still waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_load) begin
			out_placed_q <= place_ok;
			out_start_q  <= place_ok ? 5'(best_start_q) : 5'd0;
			out_freed_q  <= 6'(freed_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, out_freed_q, out_start_q, out_placed_q};

	// A result appears only as the sequencer leaves its final state.
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == cpa_pkg::ST_FINISH))
		else $error("result raised outside the finish state");

	// A failed placement reports page zero.
	a_fail_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[5:1] == 5'd0))
		else $error("failed placement with nonzero start page");

	// A placement claims its expiry entry.
	a_slot_claimed: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == cpa_pkg::ST_ALLOC) && place_ok) |=> exp_valid_q[$past(slot_q)])
		else $error("placed job left its expiry entry free");

	// An arrival starts a fresh expiry scan.
	a_scan_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ((state_q == cpa_pkg::ST_EXPIRE) && (idx_q == '0) && (freed_q == '0)))
		else $error("expiry scan did not start cleanly");

endmodule

// File: verif/tb_contiguous_page_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous page allocator unit testbench
// Streams job arrivals into the allocator under every placement rule and
// checks each result against a cycle-free model of the page map and expiry
// table. A short directed part covers the field extremes and corner cases.
// Random sequences of plausible arrivals with some noise and flush items
// follow, with bursty input and a patterned stall on the result side.
// ----------------------------------------------------------------------------
module tb_contiguous_page_allocator_unit;

	// Unknown rule code: the block never places under it.
	localparam logic [1:0]      FIT_NONE = 2'd3;
	localparam cpa_pkg::time_t  T_MAX    = 32'hFFFF_FFFF;

	// One job arrival, first field in the lowest bits.
	typedef struct packed {
		logic [31:0]       duration;
		logic [5:0]        page_count;
		cpa_pkg::time_t    arrival;
		cpa_pkg::job_id_t  id;
	} job_t;

	// One placement result, first field in the lowest bits.
	typedef struct packed {
		logic [5:0] freed;
		logic [4:0] start;
		logic       placed;
	} placement_t;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       cfg_wr_en   = 1'b0;
	logic [1:0]                 cfg_wr_data = cpa_pkg::FIT_FIRST;
	logic                       s_tvalid    = 1'b0;
	logic                       s_tready;
	logic [cpa_pkg::IN_W-1:0]   s_tdata     = '0;
	logic                       m_tvalid;
	logic                       m_tready    = 1'b0;
	logic [cpa_pkg::OUT_W-1:0]  m_tdata;

	// Model state of the block.
	cpa_pkg::job_id_t    page_map    [cpa_pkg::PAGES];
	logic                entry_live  [cpa_pkg::PAGES];
	cpa_pkg::job_id_t    entry_owner [cpa_pkg::PAGES];
	cpa_pkg::time_t      entry_end   [cpa_pkg::PAGES];
	logic [1:0]          fit_rule = cpa_pkg::FIT_FIRST;

	job_t                pending_jobs [$];
	placement_t          expected_placements [$];
	job_t                job_on_bus;
	cpa_pkg::time_t      now;

	int                  error_count    = 0;
	int                  accepted_count = 0;
	int                  placed_count   = 0;
	int                  released_count = 0;
	int                  rule_writes    = 0;
	int                  burst_left     = 1;
	int                  gap_left       = 0;
	int                  stall_cycle    = 0;
	int                  stall_mode     = 0;

	contiguous_page_allocator_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	// Clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Clear the model page map and expiry table as reset does.
	initial begin
		for (int i = 0; i < cpa_pkg::PAGES; i++) begin
			page_map[i]    = '0;
			entry_live[i]  = 1'b0;
			entry_owner[i] = '0;
			entry_end[i]   = '0;
		end
	end

	// Releases expired jobs, then places the arrival under the current rule.
	function automatic placement_t place_job(input job_t j);
		placement_t        r;
		int                e;
		int                p;
		int                s;
		int                run_len;
		int                best_len;
		int                best_start;
		int                slot;
		bit                have_slot;
		bit                found;
		cpa_pkg::job_id_t  gone;
		logic [32:0]       end_sum;
		r          = '0;
		best_len   = 0;
		best_start = 0;
		slot       = 0;
		have_slot  = 1'b0;
		found      = 1'b0;
		// Expiry pass: a release clears every page carrying the id.
		for (e = 0; e < cpa_pkg::PAGES; e++) begin
			if (entry_live[e] && entry_end[e] <= j.arrival) begin
				gone = entry_owner[e];
				for (p = 0; p < cpa_pkg::PAGES; p++)
					if (page_map[p] == gone)
						page_map[p] = '0;
				entry_live[e] = 1'b0;
				r.freed++;
			end
		end
		// Lowest free expiry entry.
		for (e = 0; e < cpa_pkg::PAGES; e++) begin
			if (!entry_live[e]) begin
				slot      = e;
				have_slot = 1'b1;
				break;
			end
		end
		// Hole search over maximal free runs.
		if (j.id != 0 && j.page_count != 0 && j.page_count <= cpa_pkg::PAGES &&
		    fit_rule <= cpa_pkg::FIT_WORST && have_slot) begin
			p = 0;
			while (p < cpa_pkg::PAGES) begin
				if (page_map[p] != 0) begin
					p++;
				end else begin
					s = p;
					while (p < cpa_pkg::PAGES && page_map[p] == 0)
						p++;
					run_len = p - s;
					if (run_len >= j.page_count) begin
						if (!found ||
						    (fit_rule == cpa_pkg::FIT_BEST && run_len < best_len) ||
						    (fit_rule == cpa_pkg::FIT_WORST && run_len > best_len)) begin
							found      = 1'b1;
							best_len   = run_len;
							best_start = s;
						end
						if (fit_rule == cpa_pkg::FIT_FIRST)
							break;
					end
				end
			end
		end
		// Tag the run and record the saturated end time.
		if (found) begin
			end_sum = {1'b0, j.arrival} + {1'b0, j.duration};
			for (p = best_start; p < best_start + j.page_count && p < cpa_pkg::PAGES; p++)
				page_map[p] = j.id;
			entry_live[slot]  = 1'b1;
			entry_owner[slot] = j.id;
			entry_end[slot]   = end_sum[32] ? T_MAX : end_sum[31:0];
			r.placed = 1'b1;
			r.start  = best_start[4:0];
		end
		return r;
	endfunction

	function automatic job_t make_job(input cpa_pkg::job_id_t id,
	                                  input cpa_pkg::time_t arrival,
	                                  input logic [5:0] page_count,
	                                  input logic [31:0] duration);
		job_t j;
		j.id         = id;
		j.arrival    = arrival;
		j.page_count = page_count;
		j.duration   = duration;
		return j;
	endfunction

	// Appends one arrival to the pending list.
	task automatic enqueue_job(input job_t j);
		pending_jobs = {pending_jobs, j};
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("ERROR at %0t: %s is %0d, expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	// Input driver: pops pending arrivals and sends them in bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				placement_t r;
				r = place_job(job_on_bus);
				expected_placements = {expected_placements, r};
				accepted_count++;
				placed_count   += r.placed;
				released_count += r.freed;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_jobs.size() > 0) begin
					job_on_bus = pending_jobs.pop_front();
					s_tdata  <= {2'b00, job_on_bus};
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side: stall pattern with four modes, redrawn at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			stall_cycle++;
			if (stall_cycle % 256 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: begin
					m_tready <= 1'b1;
				end
				1: begin
					m_tready <= ($urandom_range(0, 3) != 0);
				end
				2: begin
					m_tready <= (stall_cycle % 8 == 0);
				end
				default: begin
					m_tready <= stall_cycle[5];
				end
			endcase
		end
	end

	// Monitor: compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			placement_t got;
			placement_t want;
			got = m_tdata[11:0];
			if (expected_placements.size() == 0) begin
				flag_mismatch("unexpected result, placed", got.placed, 0);
			end else begin
				want = expected_placements.pop_front();
				if (got.placed !== want.placed)
					flag_mismatch("placed", got.placed, want.placed);
				if (got.start !== want.start)
					flag_mismatch("start_page", got.start, want.start);
				if (got.freed !== want.freed)
					flag_mismatch("freed_jobs", got.freed, want.freed);
			end
		end
	end

	// Waits until every arrival is sent and every result has come back.
	task automatic wait_until_drained;
		do
			@(negedge clk);
		while (pending_jobs.size() != 0 || s_tvalid || expected_placements.size() != 0);
	endtask

	task automatic set_fit_rule(input logic [1:0] rule);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= rule;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		fit_rule = rule;
		rule_writes++;
	endtask

	// Fills the expiry table with shared ids so that a later job with free
	// pages still finds no entry.
	task automatic queue_crowded_table;
		enqueue_job(make_job(8'd1, T_MAX, 6'd0, 32'd0));
		for (int k = 0; k < 31; k++)
			enqueue_job(make_job(8'd9, 32'd100, 6'd1, 32'd1000));
		enqueue_job(make_job(8'd9, 32'd100, 6'd1, 32'd1));
		enqueue_job(make_job(8'd40, 32'd101, 6'd1, 32'd1000));
		enqueue_job(make_job(8'd41, 32'd101, 6'd1, 32'd1000));
		enqueue_job(make_job(8'd42, T_MAX, 6'd3, 32'd5));
	endtask

	// Mostly plausible arrivals with random content, some noise and flushes.
	task automatic queue_random_jobs(input int count);
		int pick;
		enqueue_job(make_job(8'($urandom_range(1, 255)), T_MAX, 6'd0, 32'd0));
		now = $urandom() >> 1;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				// Flush: every end time is at or below the maximum.
				enqueue_job(make_job(8'($urandom_range(0, 255)), T_MAX, 6'd0,
				                     $urandom()));
			end else if (pick < 12) begin
				// Noise: odd sizes, zero ids, times that step back.
				enqueue_job(make_job(8'($urandom_range(0, 255)),
				    ($urandom_range(0, 1) == 0) ? now - $urandom_range(0, 50) : $urandom(),
				    6'($urandom_range(0, 63)), $urandom()));
			end else begin
				now += $urandom_range(0, 6);
				enqueue_job(make_job(
				    8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 6)
				                                   : $urandom_range(1, 255)),
				    now,
				    6'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 32)
				                                   : $urandom_range(1, 8)),
				    $urandom_range(1, 48)));
			end
		end
	endtask

	// Test sequence.
	initial begin
		logic [1:0] phase_rules [10];
		phase_rules = '{cpa_pkg::FIT_BEST, cpa_pkg::FIT_WORST, cpa_pkg::FIT_FIRST,
		                FIT_NONE, cpa_pkg::FIT_WORST, cpa_pkg::FIT_BEST,
		                cpa_pkg::FIT_FIRST, cpa_pkg::FIT_BEST, cpa_pkg::FIT_WORST,
		                cpa_pkg::FIT_FIRST};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset rule, first fit.
		enqueue_job(make_job(8'd1,   32'd0, 6'd0,  32'd5));
		enqueue_job(make_job(8'd2,   32'd0, 6'd33, 32'd5));
		enqueue_job(make_job(8'd3,   32'd0, 6'd63, 32'd5));
		enqueue_job(make_job(8'd0,   32'd0, 6'd4,  32'd5));
		enqueue_job(make_job(8'd255, 32'd0, 6'd32, 32'd0));
		enqueue_job(make_job(8'hAA,  32'd0, 6'd1,  32'd5));
		enqueue_job(make_job(8'd11,  32'd1, 6'd8,  32'hFFFF_FFFF));
		enqueue_job(make_job(8'h55,  32'd1, 6'd4,  32'd3));
		// Same id as a live job: its release clears both runs.
		enqueue_job(make_job(8'd11,  32'd2, 6'd2,  32'd1));
		enqueue_job(make_job(8'd13,  32'd3, 6'd16, 32'd10));
		enqueue_job(make_job(8'd14,  32'd4, 6'd8,  32'd2));
		enqueue_job(make_job(8'd20,  32'h7FFF_FFFF, 6'd3, 32'h8000_0000));
		enqueue_job(make_job(8'd21,  T_MAX, 6'd5,  32'hFFFF_FFFF));
		enqueue_job(make_job(8'd22,  T_MAX, 6'd32, 32'd7));
		// Time steps back: the full memory stays full.
		enqueue_job(make_job(8'd23,  32'd0, 6'd1,  32'd1));
		enqueue_job(make_job(8'd24,  T_MAX, 6'd32, 32'd0));
		enqueue_job(make_job(8'd25,  T_MAX, 6'd1,  32'd0));
		queue_crowded_table();
		wait_until_drained();

		// Random phases, one placement rule each.
		foreach (phase_rules[ph]) begin
			set_fit_rule(phase_rules[ph]);
			@(negedge clk);
			queue_random_jobs((phase_rules[ph] == FIT_NONE) ? 60 : 170);
			wait_until_drained();
		end

		repeat (100) @(posedge clk);
		if (expected_placements.size() != 0)
			flag_mismatch("results still missing", 0, expected_placements.size());
		$display("Sent %0d arrivals across %0d rule writes; %0d placed, %0d jobs released.",
		         accepted_count, rule_writes, placed_count, released_count);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches found.", error_count);
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("Timeout with %0d results outstanding.", expected_placements.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
